>>> src/bpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_pkg
// shared widths, word types, state and command types for the bright pixel
// centroid block
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int CHAN_W = 8;
  localparam int POS_W  = 12;
  localparam int THR_W  = 10;
  localparam int SUM_W  = 36;
  localparam int CNT_W  = 25;
  localparam int OUT_W  = 20;

  localparam int DEF_MAX_WIDTH     = 4096;
  localparam int DEF_MAX_HEIGHT    = 4096;
  localparam int DEF_FRACTION_BITS = 8;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic              frame_end;
  } pixel_t;

  typedef struct packed {
    logic             found;
    logic [OUT_W-1:0] centroid_x;
    logic [OUT_W-1:0] centroid_y;
  } result_t;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIVIDE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic accept;
    logic div_load;
    logic div_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage
`default_nettype wire

>>> src/bpc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_div
// restoring shift-subtract divider, one quotient bit per step
// ----------------------------------------------------------------------------
module bpc_div #(
  parameter int DIVIDEND_W = 44,
  parameter int DIVISOR_W  = 25
) (
  input  wire logic                  clk,
  input  wire logic                  load,
  input  wire logic                  step,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic      [DIVIDEND_W-1:0] quotient
);

  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W:0]    rem_shift;
  logic [DIVISOR_W+1:0]  diff;
  logic                  ge;

  always_comb begin
    rem_shift = {rem, quo[DIVIDEND_W-1]};
    diff      = {1'b0, rem_shift} - {2'b00, dvs};
    ge        = !diff[DIVISOR_W+1];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (step) begin
      rem <= ge ? diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
      quo <= {quo[DIVIDEND_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule
`default_nettype wire

>>> src/bpc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_datapath
// threshold register, coordinate accumulators, two dividers and the
// result word register
// ----------------------------------------------------------------------------
module bpc_datapath
  import bpc_pkg::*;
#(
  parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  input  wire logic [THR_W-1:0] cfg_data,
  input  wire pixel_t     pixel,
  input  wire ctrl_cmd_t  cmd,
  output dp_status_t      status,
  output result_t         result
);

  localparam int DIV_W = SUM_W + FRACTION_BITS;

  logic [THR_W-1:0] threshold;
  logic [SUM_W-1:0] sum_x;
  logic [SUM_W-1:0] sum_y;
  logic [CNT_W-1:0] count;
  logic [SUM_W-1:0] sum_x_next;
  logic [SUM_W-1:0] sum_y_next;
  logic [CNT_W-1:0] count_next;
  logic             found;

  logic             in_frame;
  logic             bright;
  logic             take;
  logic [THR_W-1:0] chan_sum;
  logic [SUM_W:0]   nx;
  logic [SUM_W:0]   ny;
  logic [DIV_W-1:0] qx;
  logic [DIV_W-1:0] qy;

  function automatic logic [OUT_W-1:0] saturate(input logic [DIV_W-1:0] q);
    logic over;
    over = |q[DIV_W-1:OUT_W];
    return over ? {OUT_W{1'b1}} : q[OUT_W-1:0];
  endfunction

  always_comb begin
    chan_sum   = THR_W'(pixel.red) + THR_W'(pixel.green) + THR_W'(pixel.blue);
    in_frame   = (32'(pixel.pos_x) < MAX_WIDTH) && (32'(pixel.pos_y) < MAX_HEIGHT);
    bright     = in_frame && (chan_sum > threshold);
    nx         = {1'b0, sum_x} + (SUM_W+1)'(pixel.pos_x);
    ny         = {1'b0, sum_y} + (SUM_W+1)'(pixel.pos_y);
    take       = bright && (count != {CNT_W{1'b1}}) && !nx[SUM_W] && !ny[SUM_W];
    sum_x_next = take ? nx[SUM_W-1:0] : sum_x;
    sum_y_next = take ? ny[SUM_W-1:0] : sum_y;
    count_next = take ? count + CNT_W'(1) : count;
  end

  assign status.last = pixel.frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (cfg_valid) begin
      threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x <= '0;
      sum_y <= '0;
      count <= '0;
    end else if (cmd.accept) begin
      if (pixel.frame_end) begin
        sum_x <= '0;
        sum_y <= '0;
        count <= '0;
      end else begin
        sum_x <= sum_x_next;
        sum_y <= sum_y_next;
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      found <= (count_next != '0);
    end
  end

  bpc_div #(
    .DIVIDEND_W (DIV_W),
    .DIVISOR_W  (CNT_W)
  ) u_div_x (
    .clk      (clk),
    .load     (cmd.div_load),
    .step     (cmd.div_step),
    .dividend (DIV_W'(sum_x_next) << FRACTION_BITS),
    .divisor  (count_next),
    .quotient (qx)
  );

  bpc_div #(
    .DIVIDEND_W (DIV_W),
    .DIVISOR_W  (CNT_W)
  ) u_div_y (
    .clk      (clk),
    .load     (cmd.div_load),
    .step     (cmd.div_step),
    .dividend (DIV_W'(sum_y_next) << FRACTION_BITS),
    .divisor  (count_next),
    .quotient (qy)
  );

  // no bright pixel gives zero centroids
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.found      <= found;
      result.centroid_x <= found ? saturate(qx) : '0;
      result.centroid_y <= found ? saturate(qy) : '0;
    end
  end

endmodule
`default_nettype wire

>>> src/bpc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_ctrl
// frame controller: accumulate, run the dividers, hand the result word on
// ----------------------------------------------------------------------------
module bpc_ctrl
  import bpc_pkg::*;
#(
  parameter int DIV_STEPS = SUM_W + DEF_FRACTION_BITS
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       pixel_valid,
  output logic            pixel_stall,
  output logic            result_valid,
  input  wire logic       result_stall,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  localparam int STEP_W = $clog2(DIV_STEPS);

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step_cnt;
  logic [STEP_W-1:0] step_cnt_next;
  logic              result_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_ACCUM;
      step_cnt     <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      step_cnt     <= step_cnt_next;
      result_valid <= result_valid_next;
    end
  end

  always_comb begin
    state_next        = state;
    step_cnt_next     = step_cnt;
    result_valid_next = result_valid && result_stall;
    cmd               = '0;
    pixel_stall       = 1'b1;
    case (state)
      ST_ACCUM: begin
        pixel_stall = 1'b0;
        cmd.accept  = pixel_valid;
        if (pixel_valid && status.last) begin
          cmd.div_load  = 1'b1;
          step_cnt_next = '0;
          state_next    = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step  = 1'b1;
        step_cnt_next = step_cnt + STEP_W'(1);
        if (step_cnt == STEP_W'(DIV_STEPS - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the output register to be free
        if (!result_valid || !result_stall) begin
          cmd.out_load      = 1'b1;
          result_valid_next = 1'b1;
          state_next        = ST_ACCUM;
        end
      end
      default: begin
        state_next = ST_ACCUM;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> src/bright_pixel_centroid.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bright_pixel_centroid
// centroid of the pixels of a frame whose red+green+blue exceeds a threshold
// ----------------------------------------------------------------------------
// Pixels are taken one per clock within a frame. A pixel is bright when
// red+green+blue is above the threshold register and its position lies
// inside MAX_WIDTH x MAX_HEIGHT. After the word marked frame_end the pixel
// input stalls while two shift-subtract dividers, one quotient bit per
// cycle, form the mean x and y, and stays stalled while the output
// register still holds an earlier result. The result word carries a found
// flag and both means in fixed point with FRACTION_BITS fractional bits,
// truncated and saturated to 20 bits. The threshold is written through the
// cfg port, which is always ready.
// ----------------------------------------------------------------------------
module bright_pixel_centroid
  import bpc_pkg::*;
#(
  parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [THR_W-1:0] cfg_data,
  input  wire logic             pixel_valid,
  output logic                  pixel_stall,
  input  wire pixel_t           pixel,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output result_t               result
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  bpc_ctrl #(
    .DIV_STEPS (SUM_W + FRACTION_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  bpc_datapath #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .pixel     (pixel),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule
`default_nettype wire

>>> src/bpc_props.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_props
// port-level checks for the bright pixel centroid block
// ----------------------------------------------------------------------------
module bpc_props
  import bpc_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    pixel_valid,
  input wire logic    pixel_stall,
  input wire pixel_t  pixel,
  input wire logic    result_valid,
  input wire logic    result_stall,
  input wire result_t result
);

  // stalled result word stays
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // no bright pixel means zero centroids
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.found |-> result.centroid_x == '0 && result.centroid_y == '0)
    else $error("centroid not zero for empty frame");

  // a frame end is followed by input stall while dividing
  a_stall_after_end: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_stall && pixel.frame_end |=> pixel_stall)
    else $error("pixel taken right after frame end");

  // nothing comes out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result word after reset");

endmodule

bind bright_pixel_centroid bpc_props u_props (
  .clk          (clk),
  .rst          (rst),
  .pixel_valid  (pixel_valid),
  .pixel_stall  (pixel_stall),
  .pixel        (pixel),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
`default_nettype wire

>>> tb/bright_pixel_centroid_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bright_pixel_centroid_tb
// self-checking bench for the bright pixel centroid block
// ----------------------------------------------------------------------------
// A short table of frames covers dark and bright frames, corner coordinates
// and the threshold extremes. Random frames follow, in phases with a fresh
// threshold each: no idling, sender gaps, receiver stalls, both, and a long
// receiver hold-off that backs the block up into its pixel input. Every
// result word is checked field by field against a word given in the table
// or a centroid predictor that keeps its own sums, count and threshold.
// ----------------------------------------------------------------------------
module bright_pixel_centroid_tb;
  import bpc_pkg::*;

  localparam int FRAC_BITS       = DEF_FRACTION_BITS;
  localparam int SETTLE_CYCLES   = SUM_W + FRAC_BITS + 1 + 16;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int HOLD_CYCLES     = 400;
  localparam int NUM_PHASES      = 5;
  localparam int ITEMS_PER_PHASE = 126;
  localparam int SND_PCT [NUM_PHASES] = '{0, 62, 0, 10, 0};
  localparam int RCV_PCT [NUM_PHASES] = '{0, 0, 62, 10, 0};
  localparam int PRESSURE_PHASE  = 4;
  localparam int ZERO_THR_PHASE  = 3;

  typedef enum logic {
    ROW_PIXEL,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [THR_W-1:0] thr;
    pixel_t           px;
    logic             typed;
    result_t          want;
  } row_t;

  localparam int NUM_ROWS = 24;
  localparam row_t DIRECTED [NUM_ROWS] = '{
    '{ROW_PIXEL, 10'd0, '{8'd0, 8'd0, 8'd0, 12'd0, 12'd0, 1'b1}, 1'b1,
      '{1'b0, 20'd0, 20'd0}},
    '{ROW_PIXEL, 10'd0, '{8'd255, 8'd255, 8'd255, 12'd4095, 12'd4095, 1'b1}, 1'b1,
      '{1'b1, 20'd1048320, 20'd1048320}},
    '{ROW_PIXEL, 10'd0, '{8'd1, 8'd0, 8'd0, 12'd0, 12'd0, 1'b1}, 1'b1,
      '{1'b1, 20'd0, 20'd0}},
    '{ROW_PIXEL, 10'd0, '{8'd0, 8'd0, 8'd1, 12'd4095, 12'd0, 1'b1}, 1'b1,
      '{1'b1, 20'd1048320, 20'd0}},
    '{ROW_PIXEL, 10'd0, '{8'd10, 8'd0, 8'd0, 12'd3, 12'd5, 1'b0}, 1'b0, '0},
    '{ROW_PIXEL, 10'd0, '{8'd0, 8'd0, 8'd0, 12'd100, 12'd100, 1'b0}, 1'b0, '0},
    '{ROW_PIXEL, 10'd0, '{8'd0, 8'd0, 8'd7, 12'd4, 12'd8, 1'b1}, 1'b0, '0},
    '{ROW_CFG, 10'd765, '0, 1'b0, '0},
    '{ROW_PIXEL, 10'd0, '{8'd255, 8'd255, 8'd255, 12'd1, 12'd1, 1'b1}, 1'b1,
      '{1'b0, 20'd0, 20'd0}},
    '{ROW_CFG, 10'd764, '0, 1'b0, '0},
    '{ROW_PIXEL, 10'd0, '{8'd255, 8'd255, 8'd255, 12'd2, 12'd3, 1'b1}, 1'b1,
      '{1'b1, 20'd512, 20'd768}},
    '{ROW_CFG, 10'd1023, '0, 1'b0, '0},
    '{ROW_PIXEL, 10'd0, '{8'd255, 8'd255, 8'd255, 12'd9, 12'd9, 1'b0}, 1'b0, '0},
    '{ROW_PIXEL, 10'd0, '{8'd255, 8'd255, 8'd255, 12'd7, 12'd7, 1'b1}, 1'b1,
      '{1'b0, 20'd0, 20'd0}},
    '{ROW_CFG, 10'd300, '0, 1'b0, '0},
    '{ROW_PIXEL, 10'd0, '{8'd100, 8'd100, 8'd100, 12'd10, 12'd20, 1'b0}, 1'b0, '0},
    '{ROW_PIXEL, 10'd0, '{8'd100, 8'd100, 8'd101, 12'd4095, 12'd0, 1'b0}, 1'b0, '0},
    '{ROW_PIXEL, 10'd0, '{8'd200, 8'd200, 8'd200, 12'd0, 12'd4095, 1'b0}, 1'b0, '0},
    '{ROW_PIXEL, 10'd0, '{8'd0, 8'd255, 8'd255, 12'd1234, 12'd2345, 1'b1}, 1'b0, '0},
    '{ROW_CFG, 10'd0, '0, 1'b0, '0},
    '{ROW_PIXEL, 10'd0, '{8'hAA, 8'h55, 8'hAA, 12'hAAA, 12'h555, 1'b0}, 1'b0, '0},
    '{ROW_PIXEL, 10'd0, '{8'h55, 8'hAA, 8'h55, 12'h555, 12'hAAA, 1'b1}, 1'b0, '0},
    '{ROW_PIXEL, 10'd0, '{8'd255, 8'd0, 8'd0, 12'd4095, 12'd4095, 1'b0}, 1'b0, '0},
    '{ROW_PIXEL, 10'd0, '{8'd0, 8'd0, 8'd0, 12'd0, 12'd0, 1'b1}, 1'b1,
      '{1'b1, 20'd1048320, 20'd1048320}}
  };

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             cfg_valid    = 1'b0;
  logic             cfg_ready;
  logic [THR_W-1:0] cfg_data     = '0;
  logic             pixel_valid  = 1'b0;
  logic             pixel_stall;
  pixel_t           pixel        = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  result_t          result;

  // centroid predictor state
  logic [THR_W-1:0] bright_thr = '0;
  logic [SUM_W-1:0] acc_x      = '0;
  logic [SUM_W-1:0] acc_y      = '0;
  logic [CNT_W-1:0] acc_n      = '0;

  result_t pending_centroids [$];
  int      mismatches    = 0;
  int      quiet_cycles  = 0;
  int      snd_idle_pct  = 0;
  int      rcv_stall_pct = 0;
  int      hold_reqs     = 0;
  int      hold_served   = 0;
  int      hold_left     = 0;
  bit      offering      = 1'b0;

  bright_pixel_centroid uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [OUT_W-1:0] fixed_mean(input logic [SUM_W-1:0] s,
                                                   input logic [CNT_W-1:0] n);
    logic [SUM_W+FRAC_BITS-1:0] q;
    if (n == 0) return '0;
    q = {s, {FRAC_BITS{1'b0}}} / n;
    if (q[SUM_W+FRAC_BITS-1:OUT_W] != 0) return '1;
    return q[OUT_W-1:0];
  endfunction

  function automatic bit centroid_step(input pixel_t p, output result_t r);
    logic [THR_W:0] chan_sum;
    logic [SUM_W:0] nx;
    logic [SUM_W:0] ny;
    chan_sum = (THR_W+1)'(p.red) + (THR_W+1)'(p.green) + (THR_W+1)'(p.blue);
    r = '0;
    if (p.pos_x < DEF_MAX_WIDTH && p.pos_y < DEF_MAX_HEIGHT && chan_sum > bright_thr) begin
      nx = (SUM_W+1)'(acc_x) + (SUM_W+1)'(p.pos_x);
      ny = (SUM_W+1)'(acc_y) + (SUM_W+1)'(p.pos_y);
      // a full accumulator drops the pixel
      if (acc_n != '1 && !nx[SUM_W] && !ny[SUM_W]) begin
        acc_x = nx[SUM_W-1:0];
        acc_y = ny[SUM_W-1:0];
        acc_n = acc_n + CNT_W'(1);
      end
    end
    if (!p.frame_end) return 1'b0;
    r.found      = (acc_n != 0);
    r.centroid_x = fixed_mean(acc_x, acc_n);
    r.centroid_y = fixed_mean(acc_y, acc_n);
    acc_x = '0;
    acc_y = '0;
    acc_n = '0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic stop_offering();
    if (offering) begin
      pixel_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic send_pixel(input pixel_t p, input bit typed, input result_t want);
    result_t r;
    if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      stop_offering();
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    pixel_valid <= 1'b1;
    pixel       <= p;
    offering = 1'b1;
    do @(posedge clk); while (pixel_stall);
    if (centroid_step(p, r)) pending_centroids.push_back(typed ? want : r);
  endtask

  task automatic drain_results();
    stop_offering();
    while (pending_centroids.size() != 0) @(posedge clk);
  endtask

  // the divider may still be busy once the last word is out
  task automatic wait_idle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    bright_thr = v;
  endtask

  task automatic send_random_frame(input int len);
    pixel_t      p;
    logic [63:0] raw;
    int          style;
    style = $urandom_range(9);
    for (int i = 0; i < len; i++) begin
      raw = {$urandom, $urandom};
      p   = raw[$bits(pixel_t)-1:0];
      if (style == 0) begin
        p.red   = '0;
        p.green = '0;
        p.blue  = '0;
      end else if (style == 1) begin
        p.red   = '1;
        p.green = '1;
        p.blue  = '1;
      end
      p.frame_end = (i == len - 1);
      send_pixel(p, 1'b0, '0);
    end
  endtask

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else if (hold_reqs != hold_served) begin
      hold_served  <= hold_served + 1;
      hold_left    <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else begin
      result_stall <= (rcv_stall_pct != 0) && ($urandom_range(99) < rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_centroids.size() == 0) begin
        report_mismatch("result word with no centroid pending");
      end else begin
        want = pending_centroids.pop_front();
        if (result.found !== want.found)
          report_mismatch($sformatf("found %b, want %b", result.found, want.found));
        if (result.centroid_x !== want.centroid_x)
          report_mismatch($sformatf("centroid_x %0d, want %0d",
                                    result.centroid_x, want.centroid_x));
        if (result.centroid_y !== want.centroid_y)
          report_mismatch($sformatf("centroid_y %0d, want %0d",
                                    result.centroid_y, want.centroid_y));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [THR_W-1:0] thr;
    int               sent;
    int               len;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        wait_idle();
        write_threshold(DIRECTED[i].thr);
      end else begin
        send_pixel(DIRECTED[i].px, DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      thr = (ph == ZERO_THR_PHASE) ? '0 : THR_W'($urandom_range(600, 150));
      write_threshold(thr);
      snd_idle_pct = SND_PCT[ph];
      rcv_stall_pct <= RCV_PCT[ph];
      if (ph == PRESSURE_PHASE) hold_reqs <= hold_reqs + 1;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
        send_random_frame(len);
        sent += len;
        if ($urandom_range(19) == 0) drain_results();
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> bright_pixel_centroid.f
src/bpc_pkg.sv
src/bpc_div.sv
src/bpc_datapath.sv
src/bpc_ctrl.sv
src/bright_pixel_centroid.sv
src/bpc_props.sv
tb/bright_pixel_centroid_tb.sv
